/* rtl/core/audio_gain_fade_stage_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the audio gain and fade stage
// Overlapping and next-cycle implication checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef AUDIO_GAIN_FADE_STAGE_MACROS_SVH
`define AUDIO_GAIN_FADE_STAGE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AGFS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("audio gain fade stage check failed");

// The consequent must hold in the cycle after the antecedent.
`define AGFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("audio gain fade stage check failed");

`endif

/* rtl/core/agfs_pkg.sv */
// ----------------------------------------------------------------------------
// Audio gain and fade stage package
// Field widths, command codes, register indexes and fixed constants.
// ----------------------------------------------------------------------------
package agfs_pkg;

	localparam int CMD_W      = 2;
	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam int UNITY_SHIFT = 14;

	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STOP   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEREO = 1'd1;

	localparam logic [GAIN_W-1:0]   GAIN_RESET = 16'd16384;
	localparam logic [SAMPLE_W-1:0] SAT_MAX    = 16'h7FFF;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

/* rtl/core/agfs_sample_if.sv */
// ----------------------------------------------------------------------------
// Sample channel interface
// Carries one command word with its source samples and end marker.
// ----------------------------------------------------------------------------
interface agfs_sample_if;
	import agfs_pkg::*;

	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	sample_t          sample_left;
	sample_t          sample_right;
	logic             last_of_source;

	modport source (output valid, command, sample_left, sample_right, last_of_source,
		input ready);
	modport sink (input valid, command, sample_left, sample_right, last_of_source,
		output ready);
endinterface

/* rtl/core/agfs_result_if.sv */
// ----------------------------------------------------------------------------
// Result channel interface
// Carries one scaled output word with its end-of-source flags.
// ----------------------------------------------------------------------------
interface agfs_result_if;
	import agfs_pkg::*;

	logic    valid;
	logic    ready;
	sample_t out_sample;
	logic    source_ended;
	logic    ended_interrupted;

	modport source (output valid, out_sample, source_ended, ended_interrupted,
		input ready);
	modport sink (input valid, out_sample, source_ended, ended_interrupted,
		output ready);
endinterface

/* rtl/core/agfs_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration write interface
// Carries one register index and its write data per word.
// ----------------------------------------------------------------------------
interface agfs_cfg_if;
	import agfs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/audio_gain_fade_stage.sv */
// ----------------------------------------------------------------------------
// Audio gain and fade stage
// Downmixes a stereo source to mono (else takes the left sample), applies gain
// and a linear fade ramp, truncates toward zero and saturates to 16 bits.
// ----------------------------------------------------------------------------
//  channel   dir   handshake     contents
//  samples   in    valid/ready   command, sample_left, sample_right, last_of_source
//  results   out   valid/ready   out_sample, source_ended, ended_interrupted
//  cfg       in    valid/ready   index, data (0 gain, 1 stereo_source)
//
// A sample word on an active source passes through the accepting state, three
// passes through the shared multiplier (gain, fade factor, reciprocal of the
// fade length) and a wait state that loads the output register once it is free.
// An idle sample word skips the multiplier; other words stay in the idle state.
// The finished word sits in an output register, and the next sample is taken
// while it waits. Reset clears all control state and sets gain to unity.
// ----------------------------------------------------------------------------
`include "audio_gain_fade_stage_macros.svh"

module audio_gain_fade_stage #(
	parameter int FADE_OUT_LEN = 128,
	parameter int FADE_IN_LEN  = 64
) (
	input logic           clk,
	input logic           arst_n,
	agfs_sample_if.sink   samples,
	agfs_result_if.source results,
	agfs_cfg_if.sink      cfg
);
	import agfs_pkg::*;

	localparam int LEN_MAX = (FADE_OUT_LEN > FADE_IN_LEN) ? FADE_OUT_LEN : FADE_IN_LEN;
	localparam int OW      = $clog2(FADE_OUT_LEN + 1);
	localparam int IW      = $clog2(FADE_IN_LEN + 1);
	localparam int DW      = $clog2(LEN_MAX + 1);
	localparam int XW      = DW + SAMPLE_W;
	localparam int RCP_W   = XW + DW;
	localparam int MB      = (RCP_W > GAIN_W) ? RCP_W : GAIN_W;
	localparam int P1_W    = 2 * SAMPLE_W;
	localparam int PW      = P1_W + MB;
	localparam int XFW     = PW - UNITY_SHIFT;

	localparam logic [63:0] RCP_NUM = 64'd1 << RCP_W;
	localparam logic [RCP_W-1:0] RCP_OUT =
		RCP_W'((RCP_NUM + 64'(FADE_OUT_LEN) - 64'd1) / 64'(FADE_OUT_LEN));
	localparam logic [RCP_W-1:0] RCP_IN =
		RCP_W'((RCP_NUM + 64'(FADE_IN_LEN) - 64'd1) / 64'(FADE_IN_LEN));

	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
	localparam logic [ST_W-1:0] ST_MUL1 = 3'd1;
	localparam logic [ST_W-1:0] ST_MUL2 = 3'd2;
	localparam logic [ST_W-1:0] ST_MUL3 = 3'd3;
	localparam logic [ST_W-1:0] ST_WAIT = 3'd4;

	logic [ST_W-1:0]     state_q, state_n;
	logic [GAIN_W-1:0]   gain_q;
	logic                stereo_q;
	logic                act_q, act_n;
	logic [OW-1:0]       fo_q, fo_n;
	logic [IW-1:0]       fi_q, fi_n;
	logic                sp_q, sp_n;
	logic                out_valid_q;

	logic [SAMPLE_W-1:0] mag_q;
	logic                neg_q;
	logic [DW-1:0]       factor_q, factor_n;
	logic [DW-1:0]       div_q, div_n;
	logic [P1_W-1:0]     p_q;
	logic [XW-1:0]       x_q;
	logic [SAMPLE_W-1:0] q_q;
	logic                ended_q, ended_n;
	logic                cut_q, cut_n;
	sample_t             out_sample_q;
	logic                out_ended_q;
	logic                out_cut_q;

	logic                accept;
	logic                sample_word;
	logic signed [SAMPLE_W:0] mix_sum;
	logic signed [SAMPLE_W:0] mix_half;
	sample_t             mono;
	logic [P1_W-1:0]     mul_a;
	logic [MB-1:0]       mul_b;
	logic [PW-1:0]       mul_res;
	logic [XFW-1:0]      xfull;
	logic [DW+14:0]      xlim;
	logic [XW-1:0]       xclamp;
	logic [RCP_W-1:0]    rcp_sel;
	logic                out_load;
	sample_t             result;

	assign accept      = samples.valid && samples.ready;
	assign sample_word = accept && (samples.command == CMD_SAMPLE);
	assign out_load    = (state_q == ST_WAIT) && (!out_valid_q || results.ready);

	assign mix_sum  = {samples.sample_left[SAMPLE_W-1], samples.sample_left}
		+ {samples.sample_right[SAMPLE_W-1], samples.sample_right};
	assign mix_half = (mix_sum + {{SAMPLE_W{1'b0}}, mix_sum[SAMPLE_W]}) >>> 1;
	assign mono     = stereo_q ? mix_half[SAMPLE_W-1:0] : samples.sample_left;

	always_comb begin
		act_n    = act_q;
		fo_n     = fo_q;
		fi_n     = fi_q;
		sp_n     = sp_q;
		factor_n = DW'(1);
		div_n    = DW'(1);
		cut_n    = 1'b0;
		ended_n  = 1'b0;
		if (accept) begin
			unique case (samples.command)
				CMD_START: begin
					sp_n = 1'b1;
				end
				CMD_STOP: begin
					if (act_q) begin
						fo_n = OW'(FADE_OUT_LEN);
						fi_n = '0;
					end
					sp_n = 1'b0;
				end
				CMD_SAMPLE: begin
					if (sp_q) begin
						if (act_q) begin
							if (fo_q == '0) begin
								fo_n = OW'(FADE_OUT_LEN);
								fi_n = '0;
							end
						end else begin
							act_n = 1'b1;
							fi_n  = IW'(FADE_IN_LEN);
							fo_n  = '0;
							sp_n  = 1'b0;
						end
					end
					if (act_n) begin
						if (fo_n != '0) begin
							factor_n = DW'(fo_n);
							div_n    = DW'(FADE_OUT_LEN);
							cut_n    = (fo_n == OW'(1));
							fo_n     = fo_n - OW'(1);
						end else if (fi_n != '0) begin
							factor_n = DW'(FADE_IN_LEN) - DW'(fi_n);
							div_n    = DW'(FADE_IN_LEN);
							fi_n     = fi_n - IW'(1);
						end
						ended_n = cut_n || samples.last_of_source;
						if (ended_n) begin
							act_n = 1'b0;
							fo_n  = '0;
							fi_n  = '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign rcp_sel = (div_q == DW'(FADE_OUT_LEN)) ? RCP_OUT : RCP_IN;

	assign mul_a   = (state_q == ST_MUL1) ? P1_W'(mag_q)
		: ((state_q == ST_MUL2) ? p_q : P1_W'(x_q));
	assign mul_b   = (state_q == ST_MUL1) ? MB'(gain_q)
		: ((state_q == ST_MUL2) ? MB'(factor_q) : MB'(rcp_sel));
	assign mul_res = PW'(mul_a) * PW'(mul_b);

	assign xfull  = mul_res[PW-1:UNITY_SHIFT];
	assign xlim   = {div_q, 15'b0};
	assign xclamp = (xfull > XFW'(xlim)) ? XW'(xlim) : xfull[XW-1:0];

	assign result = neg_q ? sample_t'(-q_q) : (q_q[SAMPLE_W-1] ? SAT_MAX : q_q);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_word) begin
					state_n = act_n || ended_n ? ST_MUL1 : ST_WAIT;
				end
			end
			ST_MUL1: state_n = ST_MUL2;
			ST_MUL2: state_n = ST_MUL3;
			ST_MUL3: state_n = ST_WAIT;
			ST_WAIT: begin
				if (out_load) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gain_q      <= GAIN_RESET;
			stereo_q    <= 1'b0;
			act_q       <= 1'b0;
			fo_q        <= '0;
			fi_q        <= '0;
			sp_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			act_q   <= act_n;
			fo_q    <= fo_n;
			fi_q    <= fi_n;
			sp_q    <= sp_n;
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_GAIN:   gain_q   <= cfg.data;
					REG_STEREO: stereo_q <= cfg.data[0];
					default: begin
					end
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_word) begin
			mag_q    <= mono[SAMPLE_W-1] ? SAMPLE_W'(-mono) : mono;
			neg_q    <= mono[SAMPLE_W-1] && (act_n || ended_n);
			factor_q <= factor_n;
			div_q    <= div_n;
			ended_q  <= ended_n;
			cut_q    <= cut_n;
			q_q      <= '0;
		end
		unique case (state_q)
			ST_MUL1: begin
				p_q <= mul_res[P1_W-1:0];
			end
			ST_MUL2: begin
				x_q <= xclamp;
			end
			ST_MUL3: begin
				q_q <= (div_q == DW'(1)) ? x_q[SAMPLE_W-1:0]
					: mul_res[RCP_W+SAMPLE_W-1:RCP_W];
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_sample_q <= result;
			out_ended_q  <= ended_q;
			out_cut_q    <= cut_q;
		end
	end

	assign samples.ready             = (state_q == ST_IDLE);
	assign cfg.ready                 = 1'b1;
	assign results.valid             = out_valid_q;
	assign results.out_sample        = out_sample_q;
	assign results.source_ended      = out_ended_q;
	assign results.ended_interrupted = out_cut_q;

	`AGFS_ASSERT_SAME(a_cut_implies_end, clk, arst_n, out_valid_q, !out_cut_q || out_ended_q)
	`AGFS_ASSERT_SAME(a_idle_counts_clear, clk, arst_n, !act_q, (fo_q == '0) && (fi_q == '0))
	`AGFS_ASSERT_SAME(a_fade_out_bound, clk, arst_n, 1'b1, fo_q <= OW'(FADE_OUT_LEN))
	`AGFS_ASSERT_NEXT(a_sample_starts_work, clk, arst_n, sample_word,
		(state_q == ST_MUL1) || (state_q == ST_WAIT))

endmodule

/* tb/agfs_result_monitor.sv */
// ----------------------------------------------------------------------------
// Result monitor for the audio gain and fade stage
// Watches the configuration, sample and result channels, keeps its own copy
// of the playback state, works out each scaled sample with its end flags and
// compares every accepted result word with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module agfs_result_monitor #(
	parameter int FADE_OUT_LEN = 128,
	parameter int FADE_IN_LEN  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	agfs_sample_if      samples,
	agfs_result_if      results,
	agfs_cfg_if         cfg,
	output int unsigned mismatches,
	output int unsigned outstanding,
	output int unsigned checked_words,
	output int unsigned cut_endings,
	output int unsigned last_endings
);
	timeunit 1ns;
	timeprecision 1ps;
	import agfs_pkg::*;

	localparam int FO_W = $clog2(FADE_OUT_LEN + 1);
	localparam int FI_W = $clog2(FADE_IN_LEN + 1);
	localparam int MAX_PRINTED = 100;

	typedef struct packed {
		sample_t out_sample;
		logic    ended;
		logic    interrupted;
	} out_word_t;

	logic [GAIN_W-1:0] gain_q;
	logic              stereo_q;
	logic              playing;
	logic [FO_W-1:0]   fade_out_left;
	logic [FI_W-1:0]   fade_in_left;
	logic              start_queued;
	out_word_t         scaled_q[$];

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_PRINTED)
			$display("MISMATCH at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	task automatic scale_and_fade(input logic [CMD_W-1:0] cmd, input sample_t left,
		input sample_t right, input logic end_mark);
		longint    mono, num, den, v, g, n;
		logic      cut;
		out_word_t w;
		cut = 1'b0;
		w = '0;
		case (cmd)
		CMD_START: begin
			start_queued = 1'b1;
		end
		CMD_STOP: begin
			if (playing) begin
				fade_out_left = FO_W'(FADE_OUT_LEN);
				fade_in_left = '0;
			end
			start_queued = 1'b0;
		end
		CMD_SAMPLE: begin
			if (start_queued) begin
				if (playing) begin
					if (fade_out_left == 0) begin
						fade_out_left = FO_W'(FADE_OUT_LEN);
						fade_in_left = '0;
					end
				end else begin
					playing = 1'b1;
					fade_in_left = FI_W'(FADE_IN_LEN);
					fade_out_left = '0;
					start_queued = 1'b0;
				end
			end
			if (playing) begin
				mono = stereo_q ? (longint'(left) + longint'(right)) / 2 : longint'(left);
				g = gain_q;
				num = mono * g;
				den = longint'(1) << UNITY_SHIFT;
				if (fade_out_left != 0) begin
					n = fade_out_left;
					num = num * n;
					den = den * FADE_OUT_LEN;
					fade_out_left = fade_out_left - 1'b1;
					cut = (fade_out_left == 0);
				end else if (fade_in_left != 0) begin
					n = fade_in_left;
					num = num * (FADE_IN_LEN - n);
					den = den * FADE_IN_LEN;
					fade_in_left = fade_in_left - 1'b1;
				end
				v = num / den;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
				if (cut || end_mark) begin
					playing = 1'b0;
					fade_out_left = '0;
					fade_in_left = '0;
					if (cut)
						cut_endings++;
					else
						last_endings++;
				end
				w.out_sample = v[SAMPLE_W-1:0];
				w.ended = cut || end_mark;
				w.interrupted = cut;
			end
			scaled_q.push_back(w);
		end
		default: ;
		endcase
	endtask

	task automatic compare_result();
		out_word_t w;
		if (scaled_q.size() == 0) begin
			report_mismatch($sformatf("result word %0d with nothing predicted", results.out_sample));
		end else begin
			w = scaled_q.pop_front();
			checked_words++;
			if (results.out_sample !== w.out_sample)
				report_mismatch($sformatf("out_sample %0d, predicted %0d",
					results.out_sample, w.out_sample));
			if (results.source_ended !== w.ended)
				report_mismatch($sformatf("source_ended %b, predicted %b",
					results.source_ended, w.ended));
			if (results.ended_interrupted !== w.interrupted)
				report_mismatch($sformatf("ended_interrupted %b, predicted %b",
					results.ended_interrupted, w.interrupted));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q = GAIN_RESET;
			stereo_q = 1'b0;
			playing = 1'b0;
			fade_out_left = '0;
			fade_in_left = '0;
			start_queued = 1'b0;
			scaled_q.delete();
			mismatches = 0;
			checked_words = 0;
			cut_endings = 0;
			last_endings = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				REG_GAIN:   gain_q = cfg.data[GAIN_W-1:0];
				REG_STEREO: stereo_q = cfg.data[0];
				default: ;
				endcase
			end
			if (samples.valid && samples.ready)
				scale_and_fade(samples.command, samples.sample_left, samples.sample_right,
					samples.last_of_source);
			if (results.valid && results.ready)
				compare_result();
		end
		outstanding = scaled_q.size();
	end
endmodule

/* tb/tb_audio_gain_fade_stage.sv */
// ----------------------------------------------------------------------------
// Testbench for the audio gain and fade stage
// Plays whole sources through the block (fade-in, natural ends, stops that
// fade out to a cut, restarts queued behind a fade-out) mixed with stray
// commands, under several gain and downmix settings and with random gaps on
// both channels, while a result monitor checks every output word.
// ----------------------------------------------------------------------------
module tb_audio_gain_fade_stage;
	timeunit 1ns;
	timeprecision 1ps;
	import agfs_pkg::*;

	localparam int FADE_OUT_LEN = 128;
	localparam int FADE_IN_LEN  = 64;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 30;

	logic        clk;
	logic        arst_n;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned words_sent;
	int unsigned hold_requests;
	int unsigned holds_served;
	int unsigned hold_left;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned checked_words;
	int unsigned cut_endings;
	int unsigned last_endings;

	agfs_sample_if samples();
	agfs_result_if results();
	agfs_cfg_if    cfg();

	audio_gain_fade_stage #(
		.FADE_OUT_LEN(FADE_OUT_LEN),
		.FADE_IN_LEN (FADE_IN_LEN)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples),
		.results(results),
		.cfg    (cfg)
	);

	agfs_result_monitor #(
		.FADE_OUT_LEN(FADE_OUT_LEN),
		.FADE_IN_LEN (FADE_IN_LEN)
	) result_monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.samples      (samples),
		.results      (results),
		.cfg          (cfg),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.checked_words(checked_words),
		.cut_endings  (cut_endings),
		.last_endings (last_endings)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#8_000_000;
		$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else if (holds_served != hold_requests) begin
			holds_served = hold_requests;
			hold_left = HOLD_CYCLES;
			results.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			results.ready <= 1'b0;
		end else begin
			results.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic sample_t rand_sample();
		case ($urandom_range(7))
		0: return 16'sh7FFF;
		1: return 16'sh8000;
		2: return 16'shFFFF;
		default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic int unsigned source_len();
		return $urandom_range(1) ? $urandom_range(1, 20) : $urandom_range(65, 150);
	endfunction

	task automatic send_word(input logic [CMD_W-1:0] cmd, input sample_t left,
		input sample_t right, input logic end_mark);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.command <= cmd;
		samples.sample_left <= left;
		samples.sample_right <= right;
		samples.last_of_source <= end_mark;
		do @(posedge clk); while (!samples.ready);
		words_sent++;
	endtask

	task automatic send_cmd(input logic [CMD_W-1:0] cmd);
		send_word(cmd, rand_sample(), rand_sample(), 1'($urandom_range(1)));
	endtask

	task automatic run_samples(input int unsigned n, input logic end_marked);
		int unsigned i;
		for (i = 0; i < n; i++)
			send_word(CMD_SAMPLE, rand_sample(), rand_sample(), end_marked && (i == n - 1));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic settle();
		samples.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input int unsigned idle_pct, input int unsigned stall_pct,
		input logic [GAIN_W-1:0] gain, input logic stereo);
		settle();
		write_reg(REG_GAIN, gain);
		write_reg(REG_STEREO, CFG_DATA_W'(stereo));
		cfg.valid <= 1'b0;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
	endtask

	task automatic play_source();
		int unsigned kind;
		int unsigned lead;
		kind = $urandom_range(9);
		lead = $urandom_range(0, 80);
		if (kind == 9) begin
			repeat ($urandom_range(4, 12))
				send_word(CMD_W'($urandom_range(3)), rand_sample(), rand_sample(),
					$urandom_range(7) == 0);
			return;
		end
		send_cmd(CMD_START);
		case (kind)
		4, 5: begin
			run_samples(lead, 1'b0);
			send_cmd(CMD_STOP);
			run_samples(FADE_OUT_LEN - 1, 1'b0);
			send_word(CMD_SAMPLE, rand_sample(), rand_sample(), 1'($urandom_range(1)));
		end
		6, 7: begin
			run_samples(lead, 1'b0);
			send_cmd(CMD_START);
			run_samples(FADE_OUT_LEN, 1'b0);
			run_samples(source_len(), 1'b1);
		end
		8: begin
			run_samples(lead, 1'b0);
			send_cmd(CMD_START);
			run_samples($urandom_range(1, 10), 1'b0);
			send_cmd(CMD_STOP);
			run_samples(FADE_OUT_LEN + 1, 1'b0);
		end
		default: run_samples(source_len(), 1'b1);
		endcase
	endtask

	task automatic play_until(input int unsigned count);
		int unsigned target;
		target = words_sent + count;
		while (words_sent < target)
			play_source();
	endtask

	initial begin
		arst_n = 1'b0;
		samples.valid = 1'b0;
		samples.command = CMD_SAMPLE;
		samples.sample_left = '0;
		samples.sample_right = '0;
		samples.last_of_source = 1'b0;
		results.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_GAIN;
		cfg.data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		words_sent = 0;
		hold_requests = 0;
		holds_served = 0;
		hold_left = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(0, 0, 16'hFFFF, 1'b1);
		send_word(CMD_SAMPLE, 16'sh7FFF, 16'sh8000, 1'b1);
		send_cmd(CMD_UNUSED);
		send_cmd(CMD_STOP);
		send_cmd(CMD_START);
		send_word(CMD_SAMPLE, 16'sh7FFF, 16'sh7FFF, 1'b0);
		send_word(CMD_SAMPLE, 16'sh8000, 16'sh8000, 1'b0);
		send_word(CMD_SAMPLE, -16'sd1, 16'sd0, 1'b0);
		send_word(CMD_SAMPLE, 16'sd1, -16'sd2, 1'b0);
		send_word(CMD_SAMPLE, 16'sh7FFF, 16'sh8000, 1'b0);
		send_cmd(CMD_START);
		send_word(CMD_SAMPLE, 16'sh8000, -16'sd1, 1'b0);
		send_word(CMD_SAMPLE, 16'sh7FFF, 16'sh7FFF, 1'b0);
		send_cmd(CMD_STOP);
		send_cmd(CMD_START);
		send_cmd(CMD_STOP);
		send_word(CMD_SAMPLE, 16'sh8000, 16'sh7FFF, 1'b0);
		send_word(CMD_SAMPLE, -16'sd1, -16'sd1, 1'b1);
		send_word(CMD_SAMPLE, 16'sh7FFF, 16'sh7FFF, 1'b0);
		send_cmd(CMD_START);
		send_cmd(CMD_UNUSED);
		send_word(CMD_SAMPLE, 16'sh7FFF, 16'sh7FFF, 1'b1);

		configure(0, 0, GAIN_RESET, 1'b0);
		hold_requests++;
		send_cmd(CMD_START);
		run_samples(60, 1'b0);
		play_until(400);

		configure(49, 0, 16'hFFFF, 1'b1);
		play_until(225);
		settle();
		play_until(225);

		configure(0, 49, 16'd0, 1'b0);
		play_until(450);

		configure(28, 28, GAIN_W'($urandom), 1'b1);
		play_until(225);
		configure(28, 28, 16'd1, 1'($urandom_range(1)));
		play_until(225);

		settle();
		$display("Sent %0d words and checked %0d results across six gain/downmix settings.",
			words_sent, checked_words);
		$display("Sources ended by fade-out cut: %0d, on their final sample: %0d.",
			cut_endings, last_endings);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
